// File: rtl/core/htfd_pkg.sv
// shared types, constants and the crc-8 step for the sensor frame decoder
// no dependencies; compiled before every other file of the block

package htfd_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [14:0] TMP_SCALE = 15'd20000;
  localparam logic [15:0] TMP_OFFSET = 16'd5000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] raw_humidity;
    logic [19:0] raw_temperature;
  } frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/htfd_if.sv
// valid/ready channel interfaces for the byte input and the decoded frame output
// depends on htfd_pkg

interface htfd_in_if;
  import htfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source(output valid, rx_byte, frame_start, input ready);
  modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_out_if;
  import htfd_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic        [19:0] raw_humidity;
  logic        [19:0] raw_temperature;
  logic        [13:0] humidity_centi;
  logic signed [14:0] temperature_centi;
  modport source(output valid, status, raw_humidity, raw_temperature, humidity_centi,
                 temperature_centi, input ready);
  modport sink(input valid, status, raw_humidity, raw_temperature, humidity_centi,
               temperature_centi, output ready);
endinterface

// File: rtl/core/htfd_front.sv
// front end: byte counting, crc-8, busy flag and raw field shift registers
// depends on htfd_pkg; pushes one frame record per reply into the queue

module htfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  htfd_pkg::q_stat_t q_stat,
  output htfd_pkg::q_push_t q_wr
);
  import htfd_pkg::*;

  localparam logic [2:0] IDX_STATUS = 3'd0;
  localparam logic [2:0] IDX_HUM_LO = 3'd2;
  localparam logic [2:0] IDX_MIXED  = 3'd3;
  localparam logic [2:0] IDX_CRC    = 3'd6;

  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        busy_r, busy_nxt;
  logic [19:0] hum_r, hum_nxt;
  logic [19:0] tmp_r, tmp_nxt;

  logic [2:0]  idx;
  logic [7:0]  crc_base;
  logic        accept;
  status_t     status;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign idx      = frame_start ? IDX_STATUS : idx_r;
  assign crc_base = (idx == IDX_STATUS) ? CRC_INIT : crc_r;

  always_comb begin
    if (busy_r) begin
      status = ST_BUSY;
    end else if (crc_r != rx_byte) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    busy_nxt = busy_r;
    hum_nxt  = hum_r;
    tmp_nxt  = tmp_r;
    q_wr.push                  = 1'b0;
    q_wr.frame.status          = status;
    q_wr.frame.raw_humidity    = (status == ST_OK) ? hum_r : 20'd0;
    q_wr.frame.raw_temperature = (status == ST_OK) ? tmp_r : 20'd0;
    if (accept) begin
      if (idx == IDX_CRC) begin
        q_wr.push = 1'b1;
        idx_nxt   = IDX_STATUS;
        crc_nxt   = CRC_INIT;
      end else begin
        crc_nxt = crc8_byte(crc_base, rx_byte);
        idx_nxt = idx + 3'd1;
        if (idx == IDX_STATUS) begin
          busy_nxt = rx_byte[7];
        end else if (idx <= IDX_HUM_LO) begin
          hum_nxt = {hum_r[11:0], rx_byte};
        end else if (idx == IDX_MIXED) begin
          hum_nxt = {hum_r[15:0], rx_byte[7:4]};
          tmp_nxt = {16'd0, rx_byte[3:0]};
        end else begin
          tmp_nxt = {tmp_r[11:0], rx_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= IDX_STATUS;
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
      hum_r  <= 20'd0;
      tmp_r  <= 20'd0;
    end else begin
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
      hum_r  <= hum_nxt;
      tmp_r  <= tmp_nxt;
    end
  end

endmodule

// File: rtl/core/htfd_queue.sv
// short frame queue between the front end and the scaling back end
// depends on htfd_pkg

module htfd_queue #(
  parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  htfd_pkg::q_push_t q_wr,
  input  logic              pop,
  output htfd_pkg::frame_t  rd_frame,
  output htfd_pkg::q_stat_t q_stat
);
  import htfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_frame     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/htfd_back.sv
// back end: scales raw fields to hundredths and holds the output register
// depends on htfd_pkg; pops frame records from the queue

module htfd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  htfd_pkg::q_stat_t        q_stat,
  input  htfd_pkg::frame_t         rd_frame,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output htfd_pkg::status_t        out_status,
  output logic              [19:0] out_raw_humidity,
  output logic              [19:0] out_raw_temperature,
  output logic              [13:0] out_humidity_centi,
  output logic signed       [14:0] out_temperature_centi
);
  import htfd_pkg::*;

  logic               valid_r;
  status_t            status_r;
  logic        [19:0] rh_r;
  logic        [19:0] rt_r;
  logic        [13:0] hc_r;
  logic signed [14:0] tc_r;

  logic [33:0] hum_prod;
  logic [34:0] tmp_prod;
  logic [15:0] tmp_diff;
  logic [13:0] hc_nxt;
  logic [14:0] tc_nxt;

  assign pop      = !q_stat.empty && (!valid_r || out_ready);
  assign hum_prod = {14'd0, rd_frame.raw_humidity} * {20'd0, HUM_SCALE};
  assign tmp_prod = {15'd0, rd_frame.raw_temperature} * {20'd0, TMP_SCALE};
  assign tmp_diff = {1'b0, tmp_prod[34:20]} - TMP_OFFSET;
  assign hc_nxt   = (rd_frame.status == ST_OK) ? hum_prod[33:20] : 14'd0;
  assign tc_nxt   = (rd_frame.status == ST_OK) ? tmp_diff[14:0] : 15'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= rd_frame.status;
      rh_r     <= rd_frame.raw_humidity;
      rt_r     <= rd_frame.raw_temperature;
      hc_r     <= hc_nxt;
      tc_r     <= signed'(tc_nxt);
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_raw_humidity      = rh_r;
  assign out_raw_temperature   = rt_r;
  assign out_humidity_centi    = hc_r;
  assign out_temperature_centi = tc_r;

endmodule

// File: rtl/core/humidity_temp_frame_decoder_unit.sv
// top level of the humidity/temperature sensor frame decoder
// depends on htfd_pkg, htfd_if, htfd_front, htfd_queue, htfd_back
//
// channel  dir  handshake    carries
// in_ch    in   valid/ready  rx_byte, frame_start (one reply byte per item)
// out_ch   out  valid/ready  status, raw fields, scaled humidity and temperature
//
// one byte per cycle while ready; a crc byte's result is queued, then registered
// in_ch.ready follows the frame queue (QUEUE_DEPTH frames): it drops only when full
// out_ch stalls hold the output register; the queue absorbs frames meanwhile
// synchronous active-low reset clears the byte count, crc, queue and output valid

module humidity_temp_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  htfd_in_if.sink    in_ch,
  htfd_out_if.source out_ch
);
  import htfd_pkg::*;

  q_push_t q_wr;
  q_stat_t q_stat;
  frame_t  rd_frame;
  logic    pop;

  htfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .q_stat      (q_stat),
    .q_wr        (q_wr)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .pop      (pop),
    .rd_frame (rd_frame),
    .q_stat   (q_stat)
  );

  htfd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .rd_frame              (rd_frame),
    .pop                   (pop),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_status            (out_ch.status),
    .out_raw_humidity      (out_ch.raw_humidity),
    .out_raw_temperature   (out_ch.raw_temperature),
    .out_humidity_centi    (out_ch.humidity_centi),
    .out_temperature_centi (out_ch.temperature_centi)
  );

endmodule

// File: rtl/core/htfd_checker.sv
// port-level assertions for the frame decoder, bound to the top level
// depends on htfd_pkg and humidity_temp_frame_decoder_unit

module htfd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input htfd_pkg::status_t        out_status,
  input logic              [19:0] out_raw_humidity,
  input logic              [19:0] out_raw_temperature,
  input logic              [13:0] out_humidity_centi,
  input logic signed       [14:0] out_temperature_centi
);
  import htfd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_raw_humidity) && $stable(out_raw_temperature)
      && $stable(out_humidity_centi) && $stable(out_temperature_centi))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_raw_humidity == 20'd0
      && out_raw_temperature == 20'd0 && out_humidity_centi == 14'd0
      && out_temperature_centi == 15'sd0)
    else $error("failed frame carries nonzero fields");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_humidity_centi <= 14'd9999
      && out_temperature_centi >= -15'sd5000 && out_temperature_centi <= 15'sd14999)
    else $error("scaled value out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_BUSY || out_status == ST_CRC_ERR)
    else $error("invalid status code");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_status            (out_ch.status),
  .out_raw_humidity      (out_ch.raw_humidity),
  .out_raw_temperature   (out_ch.raw_temperature),
  .out_humidity_centi    (out_ch.humidity_centi),
  .out_temperature_centi (out_ch.temperature_centi)
);

// File: tb/tb_top.sv
// self-checking testbench for humidity_temp_frame_decoder_unit: reply bytes go in one item
// at a time, decoded readings are checked against an in-bench model of the decoder
// depends on htfd_pkg, htfd_if and the decoder rtl

module tb_top;
  import htfd_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int TAIL_ITEMS = 100;
  localparam int LONG_HOLD = 80;
  localparam int DIR_ROWS = 22;

  typedef enum logic [1:0] {
    CRC_LITERAL,
    CRC_MATCH,
    CRC_BROKEN
  } crc_pick_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    crc_pick_t  pick;
    logic       typed;
    status_t    t_status;
  } byte_row_t;

  typedef struct packed {
    status_t            status;
    logic [19:0]        rh;
    logic [19:0]        rt;
    logic [13:0]        hc;
    logic signed [14:0] tc;
  } reading_t;

  logic clk;
  logic rst_n;
  int errors;
  int items_sent;
  bit quiet_tail;
  bit long_stall_req;
  reading_t readings_due[$];
  reading_t due;

  logic [2:0]  pos_model;
  logic [7:0]  crc_model;
  logic        busy_model;
  logic [19:0] hum_model;
  logic [19:0] tmp_model;

  htfd_in_if in_ch();
  htfd_out_if out_ch();

  humidity_temp_frame_decoder_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // busy reply, max fields with good crc and no frame start, restart mid-reply, crc error
  byte_row_t dir_rows [DIR_ROWS] = '{
    '{8'h80, 1'b1, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b1, ST_BUSY},
    '{8'h1C, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'hFF, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_MATCH,   1'b0, ST_OK},
    '{8'h40, 1'b1, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b1, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_LITERAL, 1'b0, ST_OK},
    '{8'h00, 1'b0, CRC_BROKEN,  1'b1, ST_CRC_ERR}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic decode_model_byte(input logic [7:0] b, input logic s,
                                             output reading_t r);
    logic [2:0] idx;
    idx = s ? 3'd0 : pos_model;
    r = '0;
    if (idx == 3'd0) begin
      crc_model = 8'hFF;
    end
    if (idx < 3'd6) begin
      crc_model = crc_step(crc_model, b);
      if (idx == 3'd0) begin
        busy_model = b[7];
      end else if (idx <= 3'd2) begin
        hum_model = {hum_model[11:0], b};
      end else if (idx == 3'd3) begin
        hum_model = {hum_model[15:0], b[7:4]};
        tmp_model = {16'd0, b[3:0]};
      end else begin
        tmp_model = {tmp_model[11:0], b};
      end
      pos_model = idx + 3'd1;
      return 1'b0;
    end
    if (busy_model) begin
      r.status = ST_BUSY;
    end else if (crc_model != b) begin
      r.status = ST_CRC_ERR;
    end else begin
      r.status = ST_OK;
      r.rh = hum_model;
      r.rt = tmp_model;
      r.hc = 14'((64'(hum_model) * 64'd10000) >> 20);
      r.tc = 15'(((64'(tmp_model) * 64'd20000) >> 20) - 64'd5000);
    end
    pos_model = 3'd0;
    crc_model = 8'hFF;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                           input status_t t_status);
    reading_t r;
    logic has;
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_start <= s;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    has = decode_model_byte(b, s, r);
    if (has) begin
      if (typed) begin
        r = '{t_status, 20'd0, 20'd0, 14'd0, 15'sd0};
      end
      readings_due.push_back(r);
    end
    items_sent++;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic send_reply(input int len, input logic s);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        b = 8'($urandom_range(0, 255));
        b[7] = ($urandom_range(0, 3) == 0);
      end else if (k < 6) begin
        b = pick_data();
      end else begin
        case ($urandom_range(0, 9))
          0, 1: b = crc_model ^ 8'($urandom_range(1, 255));
          2: b = 8'($urandom_range(0, 255));
          default: b = crc_model;
        endcase
      end
      send_byte(b, (k == 0) ? s : 1'b0, 1'b0, ST_OK);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time,
                 out_ch.status);
        errors++;
      end else begin
        due = readings_due.pop_front();
        check_field("status", due.status, out_ch.status);
        check_field("raw_humidity", due.rh, out_ch.raw_humidity);
        check_field("raw_temperature", due.rt, out_ch.raw_temperature);
        check_field("humidity_centi", due.hc, out_ch.humidity_centi);
        check_field("temperature_centi", due.tc, out_ch.temperature_centi);
      end
    end
  end

  // receiver: random hold-off bursts, one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] b;
    int kind;
    bit stall_done;
    bit pause_done;
    errors = 0;
    items_sent = 0;
    quiet_tail = 1'b0;
    long_stall_req = 1'b0;
    stall_done = 1'b0;
    pause_done = 1'b0;
    pos_model = 3'd0;
    crc_model = 8'hFF;
    busy_model = 1'b0;
    hum_model = 20'd0;
    tmp_model = 20'd0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    in_ch.frame_start = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].pick)
        CRC_MATCH: b = crc_model;
        CRC_BROKEN: b = crc_model ^ 8'h01;
        default: b = dir_rows[i].data;
      endcase
      send_byte(b, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].t_status);
    end
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if (!stall_done && items_sent >= 300) begin
        stall_done = 1'b1;
        long_stall_req = 1'b1;
      end
      if (!pause_done && items_sent >= 550) begin
        pause_done = 1'b1;
        drain_results();
      end
      quiet_tail = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        send_reply(7, $urandom_range(0, 9) != 0);
      end else if (kind < 92) begin
        send_reply($urandom_range(1, 6), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, ST_OK);
        end
      end
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/htfd_pkg.sv
rtl/core/htfd_if.sv
rtl/core/htfd_front.sv
rtl/core/htfd_queue.sv
rtl/core/htfd_back.sv
rtl/core/humidity_temp_frame_decoder_unit.sv
rtl/core/htfd_checker.sv
tb/tb_top.sv
